@@ src/chunk_loudness_barge_in_detector_assert.svh @@
// Assertion macros used by the checker file of the loudness detector.
// Depends on nothing; every macro expands to one labeled concurrent assertion.
`ifndef CHUNK_LOUDNESS_BARGE_IN_DETECTOR_ASSERT_SVH
`define CHUNK_LOUDNESS_BARGE_IN_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLBD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("loudness detector assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLBD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("loudness detector assertion failed");

`endif

@@ src/clbd_pkg.sv @@
// Shared types and constants of the chunk loudness detector.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package clbd_pkg;

    localparam int MAX_CHUNK  = 1024;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = SAMPLE_W + $clog2(MAX_CHUNK);
    localparam int COUNT_W    = $clog2(MAX_CHUNK + 1);
    localparam int LEVEL_W    = 24;
    localparam int FRAC_W     = 8;
    localparam int DIV_STEPS  = SUM_W + FRAC_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam int VAD_W      = 15;
    localparam int IRQ_THR_W  = 16;
    localparam int GAIN_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [VAD_W-1:0]     VAD_RESET  = VAD_W'(500);
    localparam logic [IRQ_THR_W-1:0] IRQ_RESET  = IRQ_THR_W'(2500);
    localparam logic [GAIN_W-1:0]    GAIN_RESET = GAIN_W'(51);
    localparam logic [GAIN_W-1:0]    GAIN_ONE   = GAIN_W'(256);

    localparam logic [CFG_IDX_W-1:0] CFG_VAD_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd2;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int OUT_DATA_W = 56;

    // One finished chunk handed from the front to the back.
    typedef struct packed {
        logic [SUM_W-1:0]   abs_sum;
        logic [COUNT_W-1:0] count;
        logic               speaking;
        logic               stt;
    } job_t;

endpackage

`default_nettype wire

@@ src/clbd_front.sv @@
// Front end: takes sample beats, accumulates absolute values per chunk and
// pushes a finished chunk into the job queue. Depends on clbd_pkg.
`default_nettype none

module clbd_front import clbd_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_beat,
    input  wire logic [SAMPLE_W-1:0] sample,
    input  wire logic                last,
    input  wire logic                speaking,
    input  wire logic                stt,
    output logic                     push,
    output job_t                     job
);

    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [SAMPLE_W:0]   mag;

    // The most negative sample maps to 32768, which needs the extra bit.
    assign mag = sample[SAMPLE_W-1]
               ? ((SAMPLE_W+1)'(1) << SAMPLE_W) - {1'b0, sample}
               : {1'b0, sample};

    always_comb begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (count_reg < COUNT_W'(MAX_CHUNK)) begin
            sum_next   = sum_reg + SUM_W'(mag);
            count_next = count_reg + COUNT_W'(1);
        end
    end

    assign push = in_beat && last;
    always_comb begin
        job.abs_sum  = sum_next;
        job.count    = count_next;
        job.speaking = speaking;
        job.stt      = stt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
        end else if (in_beat) begin
            if (last) begin
                sum_reg   <= '0;
                count_reg <= '0;
            end else begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/clbd_fifo.sv @@
// Short job queue between front and back so that each side stalls on its own.
// Depends on clbd_pkg for the job type and depth.
`default_nettype none

module clbd_fifo import clbd_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  job_t      push_job,
    input  wire logic pop,
    output job_t      head_job,
    output logic      full,
    output logic      empty
);

    job_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_push, do_pop;

    assign full     = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1))
                            ? '0 : wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1))
                            ? '0 : rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + FIFO_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - FIFO_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ src/clbd_back.sv @@
// Back end: bit-serial mean division, voice test, exponential average and the
// result register, plus the configuration registers. Depends on clbd_pkg.
`default_nettype none

module clbd_back import clbd_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  job_t                       head_job,
    input  wire logic                  job_empty,
    output logic                       job_pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [LEVEL_W-1:0]         out_mean,
    output logic                       out_voice,
    output logic                       out_irq,
    output logic                       out_fwd,
    output logic [LEVEL_W-1:0]         out_smoothed
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_SUM,
        S_OUT
    } state_t;

    localparam int PROD_W = GAIN_W + LEVEL_W;
    localparam int VPROD_W = VAD_W + COUNT_W;

    state_t               state_reg;
    job_t                 job_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [COUNT_W-1:0]   rem_reg;
    logic [DIV_STEPS-1:0] num_reg;
    logic [LEVEL_W-1:0]   mean_reg;
    logic [PROD_W-1:0]    pnew_reg, pold_reg;
    logic [VPROD_W-1:0]   vprod_reg;
    logic [LEVEL_W-1:0]   avg_calc_reg;
    logic                 voice_reg;
    logic [LEVEL_W-1:0]   smoothed_reg;

    logic [VAD_W-1:0]     vad_thr_reg;
    logic [IRQ_THR_W-1:0] irq_thr_reg;
    logic [GAIN_W-1:0]    gain_reg;

    logic                 out_valid_reg;
    logic [LEVEL_W-1:0]   out_mean_reg, out_smoothed_reg;
    logic                 out_voice_reg, out_irq_reg, out_fwd_reg;

    logic [COUNT_W:0]     trial;
    logic                 qbit;
    logic [GAIN_W-1:0]    gain_sat;
    logic [PROD_W:0]      ema_sum;
    logic                 irq_hit;
    logic                 out_free;

    // One quotient bit per cycle; the remainder always stays below the count.
    assign trial = {rem_reg, num_reg[DIV_STEPS-1]};
    assign qbit  = (trial >= {1'b0, job_reg.count});

    assign gain_sat = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;
    assign ema_sum  = {1'b0, pnew_reg} + {1'b0, pold_reg};
    assign irq_hit  = job_reg.speaking && (avg_calc_reg >= {irq_thr_reg, FRAC_W'(0)});
    assign out_free = !out_valid_reg || out_ready;
    assign job_pop  = (state_reg == S_IDLE) && !job_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vad_thr_reg <= VAD_RESET;
            irq_thr_reg <= IRQ_RESET;
            gain_reg    <= GAIN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_VAD_THR: vad_thr_reg <= cfg_wdata[VAD_W-1:0];
                CFG_IRQ_THR: irq_thr_reg <= cfg_wdata[IRQ_THR_W-1:0];
                CFG_GAIN:    gain_reg    <= cfg_wdata[GAIN_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            smoothed_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if ((state_reg == S_OUT) && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (!job_empty) begin
                        job_reg   <= head_job;
                        num_reg   <= {head_job.abs_sum, FRAC_W'(0)};
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    rem_reg  <= qbit ? COUNT_W'(trial - {1'b0, job_reg.count})
                                     : COUNT_W'(trial);
                    num_reg  <= {num_reg[DIV_STEPS-2:0], qbit};
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    mean_reg  <= num_reg[LEVEL_W-1:0];
                    pnew_reg  <= gain_sat * num_reg[LEVEL_W-1:0];
                    pold_reg  <= (GAIN_ONE - gain_sat) * smoothed_reg;
                    vprod_reg <= vad_thr_reg * job_reg.count;
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    avg_calc_reg <= ema_sum[FRAC_W +: LEVEL_W];
                    voice_reg    <= (VPROD_W'(job_reg.abs_sum) > vprod_reg);
                    state_reg    <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        out_mean_reg     <= mean_reg;
                        out_voice_reg    <= voice_reg;
                        out_irq_reg      <= irq_hit;
                        out_fwd_reg      <= !job_reg.speaking && job_reg.stt;
                        // A silent agent or a fired interrupt clears the average.
                        if (job_reg.speaking && !irq_hit) begin
                            smoothed_reg     <= avg_calc_reg;
                            out_smoothed_reg <= avg_calc_reg;
                        end else begin
                            smoothed_reg     <= '0;
                            out_smoothed_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_mean     = out_mean_reg;
    assign out_voice    = out_voice_reg;
    assign out_irq      = out_irq_reg;
    assign out_fwd      = out_fwd_reg;
    assign out_smoothed = out_smoothed_reg;

endmodule

`default_nettype wire

@@ src/chunk_loudness_barge_in_detector.sv @@
// Chunk loudness detector: one sample beat per cycle on the input side while
// the job queue is not full. After the marked last beat the chunk passes the
// bit-serial mean divider and then the multiply, sum and output stages of the
// back end, which takes the next chunk only once the last result is registered;
// a two-entry job queue absorbs short chunks. Reset (aresetn, low, synchronous)
// clears the state, chunk and queue counts and average; reloads the config registers.
`default_nettype none

module chunk_loudness_barge_in_detector import clbd_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [15:0] sample
    input  wire logic                  s_tlast,
    input  wire logic [1:0]            s_tuser,   // [0] agent_speaking, [1] stt_enabled
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [23:0] mean_level, [24] voice_active, [25] interrupt_request,
    // [26] forward_chunk, [50:27] smoothed_level, [55:51] zero
    output logic [OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic               in_beat;
    logic               push;
    job_t               push_job, head_job;
    logic               q_full, q_empty, q_pop;
    logic [LEVEL_W-1:0] out_mean, out_smoothed;
    logic               out_voice, out_irq, out_fwd;

    assign s_tready = !q_full;
    assign in_beat  = s_tvalid && s_tready;

    clbd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_beat  (in_beat),
        .sample   (s_tdata),
        .last     (s_tlast),
        .speaking (s_tuser[0]),
        .stt      (s_tuser[1]),
        .push     (push),
        .job      (push_job)
    );

    clbd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    clbd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .head_job     (head_job),
        .job_empty    (q_empty),
        .job_pop      (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_mean     (out_mean),
        .out_voice    (out_voice),
        .out_irq      (out_irq),
        .out_fwd      (out_fwd),
        .out_smoothed (out_smoothed)
    );

    assign m_tdata = {5'd0, out_smoothed, out_fwd, out_irq, out_voice, out_mean};

endmodule

`default_nettype wire

@@ src/clbd_checker.sv @@
// Port-level checker for the loudness detector, bound to the top level.
// Depends on the assertion macro header.
`default_nettype none
`include "chunk_loudness_barge_in_detector_assert.svh"

module clbd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata
);

    `CLBD_ASSERT_NXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `CLBD_ASSERT_NXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    // A fired interrupt always reports a cleared average.
    `CLBD_ASSERT_IMP(a_irq_clears, aclk, aresetn, m_tvalid && m_tdata[25], m_tdata[50:27] == 24'd0)
    // Forwarding only happens while the agent is silent, so never with an interrupt.
    `CLBD_ASSERT_IMP(a_fwd_no_irq, aclk, aresetn, m_tvalid && m_tdata[26], !m_tdata[25])

endmodule

bind chunk_loudness_barge_in_detector clbd_checker u_clbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
